@@ src/csc_pkg.sv @@
// Shared types and constants for the color sensor classifier.
// No dependencies; every other file refers to it by scoped names.
package csc_pkg;

    // Filter and color codes share one encoding
    typedef enum logic [1:0] {
        COL_WHITE = 2'd0,
        COL_RED   = 2'd1,
        COL_GREEN = 2'd2,
        COL_BLUE  = 2'd3
    } t_color;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_RED_LOW    = 3'd0,
        CFG_RED_HIGH   = 3'd1,
        CFG_GREEN_LOW  = 3'd2,
        CFG_GREEN_HIGH = 3'd3,
        CFG_BLUE_LOW   = 3'd4,
        CFG_BLUE_HIGH  = 3'd5,
        CFG_WHITE_MIN  = 3'd6,
        CFG_EXP_SEQ    = 3'd7
    } t_cfg_idx;

    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned SEQ_W    = 6;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned HOLD_W   = 10;

    // Counter must pass this before a color is accepted
    localparam logic [HOLD_W-1:0] HOLD_COUNT = 10'd200;

    // Window registers (all bounds exclusive)
    typedef struct packed {
        logic [COUNT_W-1:0] red_low;
        logic [COUNT_W-1:0] red_high;
        logic [COUNT_W-1:0] green_low;
        logic [COUNT_W-1:0] green_high;
        logic [COUNT_W-1:0] blue_low;
        logic [COUNT_W-1:0] blue_high;
        logic [COUNT_W-1:0] white_min;
    } t_windows;

    // One result item
    typedef struct packed {
        t_color filter_select;
        logic   led_red;
        logic   led_green;
        logic   tone_on;
        t_color accepted_color;
        t_color history_newest;
        t_color history_middle;
        t_color history_oldest;
        logic   sequence_match;
    } t_result;

endpackage

@@ src/csc_in_if.sv @@
// Request channel carrying one period count per item.
// Depends on csc_pkg for field widths.
interface csc_in_if;
    logic                           valid;
    logic                           ready;
    logic [csc_pkg::COUNT_W-1:0]    period_count;

    modport source (output valid, output period_count, input ready);
    modport sink   (input valid, input period_count, output ready);
endinterface

@@ src/csc_out_if.sv @@
// Result channel: filter select, drive outputs, history and match flag.
// Depends on csc_pkg for the color type.
interface csc_out_if;
    logic               valid;
    logic               ready;
    csc_pkg::t_color    filter_select;
    logic               led_red;
    logic               led_green;
    logic               tone_on;
    csc_pkg::t_color    accepted_color;
    csc_pkg::t_color    history_newest;
    csc_pkg::t_color    history_middle;
    csc_pkg::t_color    history_oldest;
    logic               sequence_match;

    modport source (
        output valid, input ready,
        output filter_select, led_red, led_green, tone_on, accepted_color,
        output history_newest, history_middle, history_oldest, sequence_match
    );
    modport sink (
        input valid, output ready,
        input filter_select, led_red, led_green, tone_on, accepted_color,
        input history_newest, history_middle, history_oldest, sequence_match
    );
endinterface

@@ src/csc_hit.sv @@
// Window compare: decides whether a count hits the current filter's window.
// Depends on csc_pkg.
module csc_hit (
    input  csc_pkg::t_windows           i_win,
    input  csc_pkg::t_color             i_filter,
    input  logic [csc_pkg::COUNT_W-1:0] i_count,
    output logic                        o_hit
);

    always_comb begin
        unique case (i_filter)
            csc_pkg::COL_RED:   o_hit = (i_win.red_low < i_count) && (i_count < i_win.red_high);
            csc_pkg::COL_GREEN: o_hit = (i_win.green_low < i_count)
                                        && (i_count < i_win.green_high);
            csc_pkg::COL_BLUE:  o_hit = (i_win.blue_low < i_count)
                                        && (i_count < i_win.blue_high);
            default:            o_hit = i_win.white_min < i_count;
        endcase
    end

endmodule

@@ src/csc_track.sv @@
// Classifier state (filter, hold counter, accepted color, history, drives)
// and the result register. Depends on csc_pkg.
module csc_track #(
    parameter logic [csc_pkg::HOLD_W-1:0] HOLD_COUNT = csc_pkg::HOLD_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_hit,
    input  logic [csc_pkg::SEQ_W-1:0]   i_exp_seq,
    input  logic                        i_res_ready,
    output csc_pkg::t_color             o_filter,
    output logic                        o_res_valid,
    output csc_pkg::t_result            o_res
);

    csc_pkg::t_color    r_filter, n_filter;
    csc_pkg::t_color    r_last, n_last;
    logic [7:0]         r_hold, n_hold;
    csc_pkg::t_color    r_hist0, r_hist1, r_hist2;
    csc_pkg::t_color    n_hist0, n_hist1, n_hist2;
    logic [2:0]         r_drive, n_drive;     // {tone, green, red}
    logic               r_res_valid;
    csc_pkg::t_result   r_res, n_res;

    always_comb begin
        n_filter = csc_pkg::t_color'(r_filter + 2'd1);
        n_last   = r_last;
        n_hold   = r_hold;
        n_hist0  = r_hist0;
        n_hist1  = r_hist1;
        n_hist2  = r_hist2;
        n_drive  = r_drive;

        if (i_hit && (r_last != r_filter)) begin
            if ({2'b00, r_hold} > HOLD_COUNT) begin
                n_last = r_filter;
                n_hold = 8'd0;
                unique case (r_filter)
                    csc_pkg::COL_WHITE: begin
                        n_drive = 3'b000;
                        n_hist0 = csc_pkg::COL_WHITE;
                        n_hist1 = csc_pkg::COL_WHITE;
                        n_hist2 = csc_pkg::COL_WHITE;
                    end
                    default: begin
                        unique case (r_filter)
                            csc_pkg::COL_RED:   n_drive = 3'b001;
                            csc_pkg::COL_GREEN: n_drive = 3'b010;
                            default:            n_drive = 3'b100;
                        endcase
                        n_hist2 = r_hist1;
                        n_hist1 = r_hist0;
                        n_hist0 = r_filter;
                    end
                endcase
            end else if (r_hold != 8'hFF) begin
                n_hold = r_hold + 8'd1;
            end
        end

        n_res.filter_select  = n_filter;
        n_res.led_red        = n_drive[0];
        n_res.led_green      = n_drive[1];
        n_res.tone_on        = n_drive[2];
        n_res.accepted_color = n_last;
        n_res.history_newest = n_hist0;
        n_res.history_middle = n_hist1;
        n_res.history_oldest = n_hist2;
        n_res.sequence_match = (n_hist0 == i_exp_seq[1:0])
                               && (n_hist1 == i_exp_seq[3:2])
                               && (n_hist2 == i_exp_seq[5:4]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter    <= csc_pkg::COL_WHITE;
            r_last      <= csc_pkg::COL_WHITE;
            r_hold      <= 8'd0;
            r_hist0     <= csc_pkg::COL_WHITE;
            r_hist1     <= csc_pkg::COL_WHITE;
            r_hist2     <= csc_pkg::COL_WHITE;
            r_drive     <= 3'b000;
            r_res_valid <= 1'b0;
        end else begin
            if (i_step) begin
                r_filter    <= n_filter;
                r_last      <= n_last;
                r_hold      <= n_hold;
                r_hist0     <= n_hist0;
                r_hist1     <= n_hist1;
                r_hist2     <= n_hist2;
                r_drive     <= n_drive;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_res <= n_res;
        end
    end

    assign o_filter    = r_filter;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

@@ src/color_sensor_classifier_top.sv @@
// Color sensor classifier, top level.
// Depends on csc_pkg, csc_in_if, csc_out_if, csc_hit and csc_track.
//
// Usage:
//   i_req carries one period count per request, measured under the filter
//   that the previous result selected (white after reset). o_res returns
//   one result per request: the next filter select, LED and tone drives,
//   the accepted color, the three-deep color history and a match flag
//   against the expected sequence register.
//   Configuration: pulse i_cfg_we with i_cfg_idx / i_cfg_data while idle.
//   Index 0..6 are the window bounds, 7 is the expected sequence (6 bits).
//
// Timing:
//   A request is captured in an input register, classified by one level of
//   compare logic and written to the result register, which drives
//   o_res.valid. One request per cycle is sustained while the receiver does
//   not stall; the only loop is the registered state update in csc_track.
//   If the receiver stalls, the result register holds and one further
//   request waits in the input register; i_req.ready then drops.
//   Synchronous reset returns windows to their defaults, the filter and
//   accepted color to white, clears the history, drives and hold counter,
//   and empties both stages.
module color_sensor_classifier_top #(
    parameter logic [csc_pkg::HOLD_W-1:0] HOLD_COUNT = csc_pkg::HOLD_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    csc_in_if.sink                      i_req,
    csc_out_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [csc_pkg::CFG_W-1:0]   i_cfg_data
);

    csc_pkg::t_windows              r_win;
    logic [csc_pkg::SEQ_W-1:0]      r_exp_seq;

    logic                           r_in_valid;
    logic [csc_pkg::COUNT_W-1:0]    r_in_count;

    logic               step;
    logic               hit;
    logic               res_valid;
    csc_pkg::t_color    filter;
    csc_pkg::t_result   res;

    // Input stage moves on when the result register is free or draining
    assign step        = r_in_valid && (!res_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || step;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.red_low    <= 8'd20;
            r_win.red_high   <= 8'd36;
            r_win.green_low  <= 8'd10;
            r_win.green_high <= 8'd30;
            r_win.blue_low   <= 8'd15;
            r_win.blue_high  <= 8'd30;
            r_win.white_min  <= 8'd100;
            r_exp_seq        <= '0;
        end else if (i_cfg_we) begin
            unique case (csc_pkg::t_cfg_idx'(i_cfg_idx))
                csc_pkg::CFG_RED_LOW:    r_win.red_low    <= i_cfg_data;
                csc_pkg::CFG_RED_HIGH:   r_win.red_high   <= i_cfg_data;
                csc_pkg::CFG_GREEN_LOW:  r_win.green_low  <= i_cfg_data;
                csc_pkg::CFG_GREEN_HIGH: r_win.green_high <= i_cfg_data;
                csc_pkg::CFG_BLUE_LOW:   r_win.blue_low   <= i_cfg_data;
                csc_pkg::CFG_BLUE_HIGH:  r_win.blue_high  <= i_cfg_data;
                csc_pkg::CFG_WHITE_MIN:  r_win.white_min  <= i_cfg_data;
                default:                 r_exp_seq <= i_cfg_data[csc_pkg::SEQ_W-1:0];
            endcase
        end
    end

    // Input register: valid flag under reset, payload without reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_count <= i_req.period_count;
        end
    end

    csc_hit u_hit (
        .i_win    (r_win),
        .i_filter (filter),
        .i_count  (r_in_count),
        .o_hit    (hit)
    );

    csc_track #(
        .HOLD_COUNT (HOLD_COUNT)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_hit       (hit),
        .i_exp_seq   (r_exp_seq),
        .i_res_ready (o_res.ready),
        .o_filter    (filter),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result channel
    assign o_res.valid          = res_valid;
    assign o_res.filter_select  = res.filter_select;
    assign o_res.led_red        = res.led_red;
    assign o_res.led_green      = res.led_green;
    assign o_res.tone_on        = res.tone_on;
    assign o_res.accepted_color = res.accepted_color;
    assign o_res.history_newest = res.history_newest;
    assign o_res.history_middle = res.history_middle;
    assign o_res.history_oldest = res.history_oldest;
    assign o_res.sequence_match = res.sequence_match;

endmodule
